### rtl/core/rfc_pkg.sv
// Shared types, constants and the CRC32C byte update for the request frame checker.
`default_nettype none

package rfc_pkg;

    // Frame layout, in byte offsets from the first byte of a frame.
    localparam int unsigned FRAME_SIZE    = 84;
    localparam int unsigned HEADER_BYTES  = 80;
    localparam int unsigned HEADER_CRC_AT = 76;
    localparam int unsigned MAGIC_END     = 8;
    localparam int unsigned SCRATCH_END   = 24;
    localparam int unsigned IDS_END       = 64;
    localparam int unsigned POS_SAT       = 85;
    localparam int unsigned POS_W         = 7;

    // Offsets at which the version and size fields are complete.
    localparam int unsigned VERSION_DONE_AT = 15;
    localparam int unsigned TOTAL_DONE_AT   = 23;

    // Number of decoded words and the index of the scratch word.
    localparam int unsigned NUM_WORDS   = 6;
    localparam int unsigned SCRATCH_IDX = 5;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    localparam logic [15:0] MAJOR_EXPECTED = 16'd1;
    localparam logic [15:0] MINOR_EXPECTED = 16'd0;

    // Expected magic, byte 0 first.
    localparam logic [7:0] MAGIC_BYTES [8] = '{
        8'h43, 8'h48, 8'h52, 8'h4F, 8'h42, 8'h53, 8'h51, 8'h31
    };

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_LENGTH   = 3'd1,
        VERDICT_MAGIC    = 3'd2,
        VERDICT_CHECKSUM = 3'd3,
        VERDICT_VERSION  = 3'd4,
        VERDICT_SEMANTIC = 3'd5
    } t_rfc_verdict;

    // One accepted input transfer.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_rfc_beat;

    // One verdict together with the decoded fields.
    typedef struct packed {
        logic [63:0]  corr;
        logic [63:0]  grp_hi;
        logic [63:0]  grp_lo;
        logic [63:0]  target;
        logic [63:0]  source;
        t_rfc_verdict verdict;
    } t_rfc_result;

    // Reflected CRC32C update over one byte, one bit per step.
    function automatic logic [31:0] rfc_crc_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rfc_frame_track.sv
// Per-frame byte tracking: CRC accumulation, field capture and verdict logic.
`default_nettype none

module rfc_frame_track (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rfc_pkg::t_rfc_beat  i_beat,
    output rfc_pkg::t_rfc_result     o_result
);
    import rfc_pkg::*;

    localparam logic [POS_W-1:0] P_FRAME      = POS_W'(FRAME_SIZE);
    localparam logic [POS_W-1:0] P_HEADER     = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] P_HDR_CRC    = POS_W'(HEADER_CRC_AT);
    localparam logic [POS_W-1:0] P_MAGIC_END  = POS_W'(MAGIC_END);
    localparam logic [POS_W-1:0] P_SCR_END    = POS_W'(SCRATCH_END);
    localparam logic [POS_W-1:0] P_IDS_END    = POS_W'(IDS_END);
    localparam logic [POS_W-1:0] P_SAT        = POS_W'(POS_SAT);
    localparam logic [POS_W-1:0] P_VER_DONE   = POS_W'(VERSION_DONE_AT);
    localparam logic [POS_W-1:0] P_TOT_DONE   = POS_W'(TOTAL_DONE_AT);

    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_crc;
    logic [31:0]      r_hdr_crc;
    logic [31:0]      r_frm_crc;
    logic [31:0]      r_st_hdr;
    logic [31:0]      r_st_frm;
    logic             r_magic_bad;
    logic             r_version_bad;
    logic             r_semantic_bad;
    logic [63:0]      r_word [NUM_WORDS];

    logic [31:0]      n_crc;
    logic [POS_W-1:0] rel_ids;
    logic [POS_W-1:0] rel_st;
    logic [2:0]       word_sel;
    logic [2:0]       lane;
    logic [63:0]      scratch_full;
    logic             in_frame;
    logic             magic_hit;
    logic             version_hit;
    logic             semantic_hit;
    logic [31:0]      st_frm_full;
    t_rfc_verdict     verdict;

    // Byte classification for the current offset.
    always_comb begin
        in_frame     = (r_pos < P_FRAME);
        n_crc        = rfc_crc_byte(r_crc, i_beat.data);
        lane         = r_pos[2:0];
        rel_ids      = r_pos - P_SCR_END;
        word_sel     = rel_ids[5:3];
        rel_st       = r_pos - P_HDR_CRC;
        scratch_full = {i_beat.data, r_word[SCRATCH_IDX][55:0]};
        st_frm_full  = {i_beat.data, r_st_frm[23:0]};

        magic_hit = (r_pos < P_MAGIC_END) && (i_beat.data != MAGIC_BYTES[lane]);

        version_hit = (r_pos == P_VER_DONE) &&
                      ((scratch_full[15:0] != MAJOR_EXPECTED) ||
                       (scratch_full[31:16] != MINOR_EXPECTED));

        semantic_hit = ((r_pos == P_VER_DONE) &&
                        (scratch_full[63:32] != 32'(HEADER_BYTES))) ||
                       ((r_pos == P_TOT_DONE) &&
                        (scratch_full != 64'(FRAME_SIZE))) ||
                       ((r_pos >= P_IDS_END) && (r_pos < P_HDR_CRC) &&
                        (i_beat.data != 8'd0));
    end

    // Verdict in priority order, evaluated on the last byte of a frame.
    always_comb begin
        if (r_pos != P_FRAME - POS_W'(1)) begin
            verdict = VERDICT_LENGTH;
        end else if (r_magic_bad) begin
            verdict = VERDICT_MAGIC;
        end else if ((r_st_hdr != r_hdr_crc) || (st_frm_full != r_frm_crc)) begin
            verdict = VERDICT_CHECKSUM;
        end else if (r_version_bad) begin
            verdict = VERDICT_VERSION;
        end else if (r_semantic_bad || (r_word[0] == 64'd0) || (r_word[1] == 64'd0) ||
                     (r_word[0] == r_word[1]) ||
                     ((r_word[2] == 64'd0) && (r_word[3] == 64'd0)) ||
                     (r_word[4] == 64'd0)) begin
            verdict = VERDICT_SEMANTIC;
        end else begin
            verdict = VERDICT_OK;
        end

        o_result.verdict = verdict;
        if (verdict == VERDICT_OK) begin
            o_result.source = r_word[0];
            o_result.target = r_word[1];
            o_result.grp_lo = r_word[2];
            o_result.grp_hi = r_word[3];
            o_result.corr   = r_word[4];
        end else begin
            o_result.source = '0;
            o_result.target = '0;
            o_result.grp_lo = '0;
            o_result.grp_hi = '0;
            o_result.corr   = '0;
        end
    end

    // Position, running CRC and fault flags; all return to reset after a verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_crc          <= CRC_INIT;
            r_magic_bad    <= 1'b0;
            r_version_bad  <= 1'b0;
            r_semantic_bad <= 1'b0;
        end else if (i_beat.valid) begin
            if (i_beat.last) begin
                r_pos          <= '0;
                r_crc          <= CRC_INIT;
                r_magic_bad    <= 1'b0;
                r_version_bad  <= 1'b0;
                r_semantic_bad <= 1'b0;
            end else begin
                if (r_pos < P_SAT) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (r_pos < P_HEADER) begin
                    r_crc <= n_crc;
                end
                if (magic_hit) begin
                    r_magic_bad <= 1'b1;
                end
                if (version_hit) begin
                    r_version_bad <= 1'b1;
                end
                if (semantic_hit) begin
                    r_semantic_bad <= 1'b1;
                end
            end
        end
    end

    // Captured fields; every lane is written before it is read for a verdict.
    always_ff @(posedge i_clk) begin
        if (i_beat.valid && in_frame) begin
            if (r_pos == P_HDR_CRC - POS_W'(1)) begin
                r_hdr_crc <= ~n_crc;
            end
            if (r_pos == P_HEADER - POS_W'(1)) begin
                r_frm_crc <= ~n_crc;
            end
            if ((r_pos >= P_MAGIC_END) && (r_pos < P_SCR_END)) begin
                r_word[SCRATCH_IDX][lane*8 +: 8] <= i_beat.data;
            end else if ((r_pos >= P_SCR_END) && (r_pos < P_IDS_END)) begin
                r_word[word_sel][lane*8 +: 8] <= i_beat.data;
            end else if ((r_pos >= P_HDR_CRC) && (r_pos < P_HEADER)) begin
                r_st_hdr[rel_st[1:0]*8 +: 8] <= i_beat.data;
            end else if (r_pos >= P_HEADER) begin
                r_st_frm[rel_st[1:0]*8 +: 8] <= i_beat.data;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/request_frame_checker.sv
// Top level of the request frame checker: stream ports and the result register.
`default_nettype none

// Checks one 84-byte request frame arriving one byte per transfer and issues a
// single verdict transfer when the byte flagged by tlast is taken. A byte is
// taken in every cycle while the result register is empty or being drained,
// so the block sustains one byte per clock; the only limit is the single
// result register, which holds off input while a verdict waits on the master
// side. A verdict is registered and appears on the output in the cycle after
// its last byte is taken. The verdict codes are ok, length, magic, checksum,
// version and semantics, and the decoded fields are zero unless the verdict is
// ok. Position, CRC and fault flags return to reset for the next frame.

module request_frame_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Slave side.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] frame_byte
    input  wire logic         i_s_axis_tlast,   // is_last
    // Master side.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [327:0]      o_m_axis_tdata    // [2:0] verdict, [66:3] source_node,
                                                // [130:67] target_node,
                                                // [194:131] group_first_half,
                                                // [258:195] group_second_half,
                                                // [322:259] correlation_tag, rest zero
);
    import rfc_pkg::*;

    t_rfc_beat   beat;
    t_rfc_result result;
    logic        r_out_valid;
    t_rfc_result r_out;

    // Input is taken whenever the result register is free or being drained.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;

    always_comb begin
        beat.valid = i_s_axis_tvalid && o_s_axis_tready;
        beat.last  = i_s_axis_tlast;
        beat.data  = i_s_axis_tdata;
    end

    rfc_frame_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .o_result (result)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat.valid && beat.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (beat.valid && beat.last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

endmodule

`default_nettype wire
